// ----- rtl/ocsim_pkg.sv -----
// Shared widths, defaults and types for the optimal replacement cache simulator.
`timescale 1ns / 1ps
`default_nettype none

package ocsim_pkg;

    localparam int ADDR_W         = 36;
    localparam int USE_W          = 32;
    localparam int CNT_W          = 32;
    localparam int WAY_OUT_W      = 4;
    localparam int CFG_W          = 5;
    localparam int CFG_WAYS_RESET = 16;

    localparam int NUM_SETS_DEF   = 64;
    localparam int WAYS_DEF       = 16;

    localparam int MOD_STEP       = 6;
    localparam int MOD_CYC        = (ADDR_W + MOD_STEP - 1) / MOD_STEP;
    localparam int MC_W           = (MOD_CYC > 1) ? $clog2(MOD_CYC) : 1;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] tag;
        logic [USE_W-1:0]  nxt;
    } t_entry;

endpackage

`default_nettype wire

// ----- rtl/optimal_replacement_cache_sim.sv -----
// Set-associative cache simulator with furthest-next-use replacement.
// Steps: a start transfer leads to S_READ, which holds the set row; a set count that is
// not a power of two first passes S_MOD, the set remainder unit. A hit or a fill gives its
// registered result from S_READ; an eviction first runs S_TREE, the registered maximum tree.
// Busy drops in the result cycle, so the next start is taken there; no stall.
// Reset: the set memory is cleared one row a cycle, with busy high.
`timescale 1ns / 1ps
`default_nettype none

module optimal_replacement_cache_sim #(
    parameter int NUM_SETS = ocsim_pkg::NUM_SETS_DEF,
    parameter int WAYS     = ocsim_pkg::WAYS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [ocsim_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [ocsim_pkg::ADDR_W-1:0]     i_block_addr,
    input  wire logic [ocsim_pkg::USE_W-1:0]      i_next_use,
    output logic                                  o_valid,
    output logic                                  o_hit,
    output logic [ocsim_pkg::WAY_OUT_W-1:0]       o_way,
    output logic                                  o_evicted_valid,
    output logic [ocsim_pkg::ADDR_W-1:0]          o_evicted_addr,
    output logic [ocsim_pkg::CNT_W-1:0]           o_hit_count,
    output logic [ocsim_pkg::CNT_W-1:0]           o_miss_count
);
    import ocsim_pkg::*;

    localparam int  SET_W     = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam bit  SETS_POW2 = ((NUM_SETS & (NUM_SETS - 1)) == 0);
    localparam int  WI_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int  LEVELS    = $clog2(WAYS);
    localparam int  WP        = 1 << LEVELS;
    localparam int  LV_W      = (LEVELS > 0) ? $clog2(LEVELS + 1) : 1;

    typedef t_entry [WAYS-1:0] t_row;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_READ,
        S_TREE
    } t_state;

    t_state             r_state, n_state;
    logic [CFG_W-1:0]   r_ways;
    logic [SET_W-1:0]   r_clr;
    logic [SET_W-1:0]   r_set;
    logic [SET_W-1:0]   r_rem;
    logic [ADDR_W-1:0]  r_div;
    logic [MC_W-1:0]    r_mcnt;
    logic [ADDR_W-1:0]  r_addr;
    logic [USE_W-1:0]   r_use;
    logic [LV_W-1:0]    r_lvl;
    logic [CNT_W-1:0]   r_hits, r_misses;
    logic               r_valid, r_hit, r_evv;
    logic [WAY_OUT_W-1:0] r_way;
    logic [ADDR_W-1:0]  r_evaddr;

    logic               r_tv [WP];
    logic [USE_W-1:0]   r_tu [WP];
    logic [WI_W-1:0]    r_ti [WP];

    t_row               mem [NUM_SETS];
    t_row               r_row;

    logic               accept;
    logic               rd_en;
    logic [SET_W-1:0]   rd_set, pow2_set, mod_rem;
    logic               mem_we;
    logic [SET_W-1:0]   mem_waddr;
    t_row               mem_wdata;
    logic [WAYS-1:0]    active, match, empty;
    logic               hit_any, empty_any;
    logic [WI_W-1:0]    hit_way, empty_way;
    logic               res_fire, res_hit, res_ev;
    logic [WI_W-1:0]    res_way;
    logic [ADDR_W-1:0]  res_evaddr;
    logic [WI_W+WAY_OUT_W-1:0] way_ext;
    logic [SET_W:0]     t;

    assign accept   = start && (r_state == S_IDLE);
    assign busy     = (r_state != S_IDLE);
    assign pow2_set = i_block_addr[SET_W-1:0] & SET_W'(NUM_SETS - 1);

    always_comb begin
        t = {1'b0, r_rem};
        for (int k = 0; k < MOD_STEP; k++) begin
            t = {t[SET_W-1:0], r_div[ADDR_W-1-k]};
            if (t >= (SET_W+1)'(NUM_SETS)) begin
                t = t - (SET_W+1)'(NUM_SETS);
            end
        end
        mod_rem = t[SET_W-1:0];
    end

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            if (r_ways == '0) begin
                active[w] = (w == 0);
            end else begin
                active[w] = (32'(w) < 32'(r_ways));
            end
            match[w] = active[w] && r_row[w].valid && (r_row[w].tag == r_addr);
            empty[w] = active[w] && !r_row[w].valid;
        end
        hit_any   = |match;
        empty_any = |empty;
        hit_way   = '0;
        empty_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (match[w]) begin
                hit_way = WI_W'(w);
            end
            if (empty[w]) begin
                empty_way = WI_W'(w);
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        rd_en      = 1'b0;
        rd_set     = pow2_set;
        mem_we     = 1'b0;
        mem_waddr  = r_set;
        mem_wdata  = r_row;
        res_fire   = 1'b0;
        res_hit    = 1'b0;
        res_ev     = 1'b0;
        res_way    = '0;
        res_evaddr = '0;
        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
                if (r_clr == SET_W'(NUM_SETS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (SETS_POW2) begin
                        rd_en   = 1'b1;
                        n_state = S_READ;
                    end else begin
                        n_state = S_MOD;
                    end
                end
            end
            S_MOD: begin
                if (r_mcnt == MC_W'(MOD_CYC - 1)) begin
                    rd_en   = 1'b1;
                    rd_set  = mod_rem;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (hit_any) begin
                    mem_we                 = 1'b1;
                    mem_wdata[hit_way].nxt = r_use;
                    res_fire               = 1'b1;
                    res_hit                = 1'b1;
                    res_way                = hit_way;
                    n_state                = S_IDLE;
                end else if (empty_any) begin
                    mem_we               = 1'b1;
                    mem_wdata[empty_way] = '{valid: 1'b1, tag: r_addr, nxt: r_use};
                    res_fire             = 1'b1;
                    res_way              = empty_way;
                    n_state              = S_IDLE;
                end else begin
                    n_state = S_TREE;
                end
            end
            S_TREE: begin
                if (r_lvl == LV_W'(LEVELS)) begin
                    mem_we                = 1'b1;
                    mem_wdata[r_ti[0]]    = '{valid: 1'b1, tag: r_addr, nxt: r_use};
                    res_fire              = 1'b1;
                    res_ev                = 1'b1;
                    res_way               = r_ti[0];
                    res_evaddr            = r_row[r_ti[0]].tag;
                    n_state               = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        way_ext = {{WAY_OUT_W{1'b0}}, res_way};
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            r_row <= mem[rd_set];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_ways   <= CFG_W'(CFG_WAYS_RESET);
            r_clr    <= '0;
            r_mcnt   <= '0;
            r_lvl    <= '0;
            r_hits   <= '0;
            r_misses <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= res_fire;
            if (i_cfg_we) begin
                r_ways <= i_cfg_wdata;
            end
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + SET_W'(1);
            end
            if (accept) begin
                r_mcnt <= '0;
            end else if (r_state == S_MOD) begin
                r_mcnt <= r_mcnt + MC_W'(1);
            end
            if (r_state == S_READ) begin
                r_lvl <= '0;
            end else if (r_state == S_TREE) begin
                r_lvl <= r_lvl + LV_W'(1);
            end
            if (res_fire) begin
                if (res_hit) begin
                    r_hits <= r_hits + CNT_W'(1);
                end else begin
                    r_misses <= r_misses + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_addr <= i_block_addr;
            r_use  <= i_next_use;
            r_div  <= i_block_addr;
            r_rem  <= '0;
        end else if (r_state == S_MOD) begin
            r_div <= r_div << MOD_STEP;
            r_rem <= mod_rem;
        end
        if (rd_en) begin
            r_set <= rd_set;
        end
        if (res_fire) begin
            r_hit    <= res_hit;
            r_way    <= way_ext[WAY_OUT_W-1:0];
            r_evv    <= res_ev;
            r_evaddr <= res_evaddr;
        end
        if (r_state == S_READ) begin
            for (int i = 0; i < WP; i++) begin
                if (i < WAYS) begin
                    r_tv[i] <= active[i];
                    r_tu[i] <= r_row[i].nxt;
                    r_ti[i] <= WI_W'(i);
                end else begin
                    r_tv[i] <= 1'b0;
                    r_tu[i] <= '0;
                    r_ti[i] <= '0;
                end
            end
        end else if (r_state == S_TREE) begin
            for (int i = 0; i < WP / 2; i++) begin
                if (r_tv[2*i+1] && (!r_tv[2*i] || (r_tu[2*i+1] > r_tu[2*i]))) begin
                    r_tv[i] <= r_tv[2*i+1];
                    r_tu[i] <= r_tu[2*i+1];
                    r_ti[i] <= r_ti[2*i+1];
                end else begin
                    r_tv[i] <= r_tv[2*i];
                    r_tu[i] <= r_tu[2*i];
                    r_ti[i] <= r_ti[2*i];
                end
            end
        end
    end

    assign o_valid         = r_valid;
    assign o_hit           = r_hit;
    assign o_way           = r_way;
    assign o_evicted_valid = r_evv;
    assign o_evicted_addr  = r_evaddr;
    assign o_hit_count     = r_hits;
    assign o_miss_count    = r_misses;

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("start transfer did not raise busy");

    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while still busy");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_hit |-> !o_evicted_valid)
        else $error("hit reported with an eviction");

    a_evaddr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_evicted_valid |-> o_evicted_addr == '0)
        else $error("evicted address not zero without eviction");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> CNT_W'(o_hit_count + o_miss_count) ==
            CNT_W'($past(o_hit_count) + $past(o_miss_count) + CNT_W'(1)))
        else $error("hit and miss totals did not advance by one");

endmodule

`default_nettype wire

// ----- tb/tb_optimal_replacement_cache_sim.sv -----
// Testbench for the optimal replacement cache simulator: directed and random reference traces.
`timescale 1ns / 1ps

module tb_optimal_replacement_cache_sim;
    import ocsim_pkg::*;

    localparam int NUM_SETS    = NUM_SETS_DEF;
    localparam int WAYS        = WAYS_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [USE_W-1:0] NEVER = '1;

    typedef struct packed {
        logic                 hit;
        logic [WAY_OUT_W-1:0] way;
        logic                 ev_valid;
        logic [ADDR_W-1:0]    ev_addr;
        logic [CNT_W-1:0]     hits;
        logic [CNT_W-1:0]     misses;
    } t_ref_outcome;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_W-1:0]     i_cfg_wdata;
    logic                 start;
    logic                 busy;
    logic [ADDR_W-1:0]    i_block_addr;
    logic [USE_W-1:0]     i_next_use;
    logic                 o_valid;
    logic                 o_hit;
    logic [WAY_OUT_W-1:0] o_way;
    logic                 o_evicted_valid;
    logic [ADDR_W-1:0]    o_evicted_addr;
    logic [CNT_W-1:0]     o_hit_count;
    logic [CNT_W-1:0]     o_miss_count;

    optimal_replacement_cache_sim #(
        .NUM_SETS(NUM_SETS),
        .WAYS    (WAYS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .start          (start),
        .busy           (busy),
        .i_block_addr   (i_block_addr),
        .i_next_use     (i_next_use),
        .o_valid        (o_valid),
        .o_hit          (o_hit),
        .o_way          (o_way),
        .o_evicted_valid(o_evicted_valid),
        .o_evicted_addr (o_evicted_addr),
        .o_hit_count    (o_hit_count),
        .o_miss_count   (o_miss_count)
    );

    logic [ADDR_W-1:0] tag_mem [NUM_SETS*WAYS];
    logic [USE_W-1:0]  nxt_mem [NUM_SETS*WAYS];
    logic              vld_mem [NUM_SETS*WAYS];
    logic [CNT_W-1:0]  hit_total;
    logic [CNT_W-1:0]  miss_total;
    logic [CFG_W-1:0]  ways_reg;

    t_ref_outcome      outcome_q [$];
    t_ref_outcome      want;
    logic [ADDR_W-1:0] addr_pool [$];
    int                errors = 0;
    int                cycle_cnt = 0;
    int                burst_left = 0;
    bit                gaps_on = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_ref_outcome predict_access(input logic [ADDR_W-1:0] addr,
                                                    input logic [USE_W-1:0] nu);
        t_ref_outcome     r;
        int               nways;
        int               base;
        int               pick;
        int               w;
        bit               found;
        logic [USE_W-1:0] best;
        r     = '0;
        nways = (ways_reg == 0) ? 1 : ((ways_reg > WAYS) ? WAYS : int'(ways_reg));
        base  = int'(addr % NUM_SETS) * WAYS;
        pick  = 0;
        found = 1'b0;
        for (w = 0; w < nways && !found; w++) begin
            if (vld_mem[base+w] && tag_mem[base+w] == addr) begin
                pick  = w;
                found = 1'b1;
            end
        end
        if (found) begin
            r.hit = 1'b1;
            hit_total++;
            nxt_mem[base+pick] = nu;
        end else begin
            miss_total++;
            for (w = 0; w < nways && !found; w++) begin
                if (!vld_mem[base+w]) begin
                    pick  = w;
                    found = 1'b1;
                end
            end
            if (!found) begin
                best = nxt_mem[base];
                pick = 0;
                for (w = 1; w < nways; w++) begin
                    if (nxt_mem[base+w] > best) begin
                        best = nxt_mem[base+w];
                        pick = w;
                    end
                end
                r.ev_valid = 1'b1;
                r.ev_addr  = tag_mem[base+pick];
            end
            tag_mem[base+pick] = addr;
            nxt_mem[base+pick] = nu;
            vld_mem[base+pick] = 1'b1;
        end
        r.way    = pick[WAY_OUT_W-1:0];
        r.hits   = hit_total;
        r.misses = miss_total;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want_v,
                                        input logic [63:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s expected %0h got %0h", $time, name, want_v, got_v);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (outcome_q.size() == 0) begin
                $display("%0t: result with no reference outstanding", $time);
                errors++;
            end else begin
                want = outcome_q.pop_front();
                check_field("hit", want.hit, o_hit);
                check_field("way", want.way, o_way);
                check_field("evicted_valid", want.ev_valid, o_evicted_valid);
                check_field("evicted_addr", want.ev_addr, o_evicted_addr);
                check_field("hit_count", want.hits, o_hit_count);
                check_field("miss_count", want.misses, o_miss_count);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_ref(input logic [ADDR_W-1:0] addr, input logic [USE_W-1:0] nu);
        int           gap;
        t_ref_outcome pred;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = gaps_on ? $urandom_range(1, 7) : 0;
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_block_addr <= addr;
        i_next_use   <= nu;
        start        <= 1'b1;
        do @(posedge i_clk); while (busy);
        pred      = predict_access(addr, nu);
        outcome_q = {outcome_q, pred};
    endtask

    // hold off until every outstanding transfer has produced its result
    task automatic drain();
        start      <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (outcome_q.size() != 0 || busy);
    endtask

    task automatic write_ways(input logic [CFG_W-1:0] val);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        ways_reg    = val;
    endtask

    task automatic test_fill_and_hit();
        write_ways(5'd16);
        send_ref('0, '0);
        send_ref('1, NEVER);
        send_ref('0, 32'd100);
        send_ref(36'd64, 32'd5);
    endtask

    task automatic test_evict_ties();
        write_ways(5'd2);
        send_ref(36'd1, 32'd7);
        send_ref(36'd65, 32'd7);
        send_ref(36'd129, 32'd3);
        send_ref(36'd193, NEVER);
        send_ref(36'd1, 32'd0);
    endtask

    task automatic test_way_limits();
        write_ways(5'd1);
        send_ref(36'd2, 32'd5);
        send_ref(36'd66, 32'd5);
        write_ways(5'd0);
        send_ref(36'd130, 32'd9);
        write_ways(5'd31);
        send_ref(36'd2, 32'd1);
        send_ref(36'd130, 32'd4);
        // leave a stale copy above the active ways, then widen so two ways match
        write_ways(5'd2);
        send_ref(36'd67, 32'd9);
        send_ref(36'd3, 32'd1);
        write_ways(5'd1);
        send_ref(36'd3, 32'd2);
        write_ways(5'd2);
        send_ref(36'd3, 32'd6);
    endtask

    task automatic test_random_trace(input int n_items, input logic [CFG_W-1:0] cfg);
        logic [5:0]        sets [3];
        int                n_sets;
        int                pool_sz;
        int                k;
        logic [31:0]       hi;
        logic [31:0]       lo;
        logic [ADDR_W-1:0] addr;
        logic [USE_W-1:0]  nu;
        write_ways(cfg);
        gaps_on = ($urandom_range(0, 3) != 0);
        n_sets  = $urandom_range(1, 3);
        pool_sz = $urandom_range(4, 40);
        for (int s = 0; s < 3; s++) sets[s] = 6'($urandom_range(0, NUM_SETS - 1));
        addr_pool.delete();
        for (int p = 0; p < pool_sz; p++) begin
            hi        = $urandom;
            addr      = {hi[29:0], sets[$urandom_range(0, n_sets - 1)]};
            addr_pool = {addr_pool, addr};
        end
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(0, 9) < 8) begin
                addr = addr_pool[$urandom_range(0, pool_sz - 1)];
            end else begin
                hi   = $urandom;
                lo   = $urandom;
                addr = {hi[3:0], lo};
            end
            k = $urandom_range(0, 7);
            if (k == 0) begin
                nu = NEVER;
            end else if (k == 1) begin
                nu = $urandom_range(0, 3);
            end else begin
                nu = $urandom;
            end
            if ($urandom_range(0, 149) == 0) drain();
            send_ref(addr, nu);
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;
        start        = 1'b0;
        i_block_addr = '0;
        i_next_use   = '0;
        for (int e = 0; e < NUM_SETS * WAYS; e++) begin
            tag_mem[e] = '0;
            nxt_mem[e] = '0;
            vld_mem[e] = 1'b0;
        end
        hit_total  = '0;
        miss_total = '0;
        ways_reg   = CFG_W'(CFG_WAYS_RESET);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_fill_and_hit();
        test_evict_ties();
        test_way_limits();
        test_random_trace(180, 5'd16);
        test_random_trace(170, 5'd4);
        test_random_trace(170, 5'd1);
        test_random_trace(170, 5'd31);
        test_random_trace(170, 5'd0);
        test_random_trace(170, 5'd8);
        test_random_trace(170, CFG_W'($urandom_range(0, 31)));

        drain();
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
